/* src/pbil_pkg.sv */
package pbil_pkg;

    // Result kinds
    localparam logic [1:0] KIND_PIXEL     = 2'd0;
    localparam logic [1:0] KIND_HEADER    = 2'd1;
    localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;
    localparam logic [1:0] KIND_OVERSIZE  = 2'd3;

    // Characters of the file format
    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_5    = 8'h35;
    localparam logic [7:0] CHAR_6    = 8'h36;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       file_start;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] address;
        logic [7:0]  pixel_byte;
        logic [11:0] image_width;
        logic [11:0] image_height;
        logic [15:0] max_value;
        logic        grey;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        PH_MAGIC_P,
        PH_MAGIC_D,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_PIXELS,
        PH_IDLE,
        PH_SIZE_MUL,
        PH_SIZE_FIN
    } t_phase;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_GREY,
        OP_HDR_W,
        OP_HDR_H,
        OP_HDR_M,
        OP_PIX,
        OP_MUL,
        OP_FIN
    } t_dp_op;

    typedef struct packed {
        logic       clear;
        t_dp_op     op;
        logic       emit;
        logic [1:0] kind;
    } t_dp_cmd;

    typedef struct packed {
        logic file_start;
        logic is_p;
        logic is_magic_digit;
        logic sep;
        logic over;
        logic last;
        logic total_zero;
        logic out_free;
    } t_dp_sts;

endpackage

/* src/pnm_binary_image_loader_core.sv */
// Binary greyscale (P5) and colour (P6) image file loader. File bytes arrive one per
// transfer on the input channel; a byte with file_start set restarts the parse and is
// taken as the first magic byte. The header (magic, width, height, maximum value, with
// whitespace and '#' comments to end of line skipped) produces no results until it
// completes, then one "header done" result, followed by one pixel result per data byte
// carrying its store address (rows bottom-up when flip_rows was set at header end).
// Bad magic or a width/height over MAX_DIM yields one error result; afterwards, and
// after the final pixel byte, bytes are taken and dropped until the next file start.
// Rate: one byte per clock in each parse phase while the output register can take a result;
// after the byte that ends the maximum value, input pauses for the row-length by height
// multiply that sizes the image, then for loading the address counters and issuing the
// header result. Results leave through a single output register, in the cycle after the
// byte's transfer; input is held off while that register is full and not being drained.
module pnm_binary_image_loader_core #(
    parameter int MAX_DIM = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pbil_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pbil_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata
);
    import pbil_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    pbil_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // header registers, address counters, size multiply and the result register
    pbil_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

/* src/pbil_datapath.sv */
module pbil_datapath #(
    parameter int MAX_DIM = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pbil_pkg::t_in_item  i_in_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  pbil_pkg::t_dp_cmd   i_cmd,
    output pbil_pkg::t_dp_sts   o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pbil_pkg::t_out_item o_out_item
);
    import pbil_pkg::*;

    localparam logic [15:0] MaxDimVal = 16'(MAX_DIM);

    logic        r_flip_rows, n_flip_rows;
    logic        r_flip_active, n_flip_active;
    logic        r_grey, n_grey;
    logic [15:0] r_accum, n_accum;
    logic        r_digit_seen, n_digit_seen;
    logic        r_comment, n_comment;
    logic [11:0] r_width, n_width;
    logic [11:0] r_height, n_height;
    logic [15:0] r_maxval, n_maxval;
    logic [23:0] r_addr, n_addr;
    logic [13:0] r_row_cnt, n_row_cnt;
    logic [23:0] r_remaining, n_remaining;
    logic [23:0] r_total, n_total;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_item, n_out_item;

    logic [7:0]  w_byte;
    logic        w_is_digit;
    logic        w_is_hash;
    logic        w_is_eol;
    logic [3:0]  w_digit;
    logic [19:0] w_acc_wide;
    logic [13:0] w_rowlen;
    logic [13:0] w_row_cnt_inc;
    logic        w_row_end;
    logic        w_sep;
    logic        w_over;
    logic [25:0] w_product;
    logic        w_out_free;
    logic        w_is_pixel;

    assign w_byte        = i_in_item.byte_in;
    assign w_is_digit    = (w_byte >= CHAR_0) && (w_byte <= CHAR_9);
    assign w_is_hash     = (w_byte == CHAR_HASH);
    assign w_is_eol      = (w_byte == CHAR_LF) || (w_byte == CHAR_CR);
    assign w_digit       = 4'(w_byte - CHAR_0);
    // accum * 10 + digit as shift-add
    assign w_acc_wide    = ({4'b0, r_accum} << 3) + ({4'b0, r_accum} << 1) + 20'(w_digit);
    assign w_rowlen      = r_grey ? 14'(r_width) : (14'(r_width) << 1) + 14'(r_width);
    assign w_row_cnt_inc = r_row_cnt + 14'd1;
    assign w_row_end     = (w_row_cnt_inc >= w_rowlen);
    assign w_sep         = !r_comment && !w_is_digit && r_digit_seen;
    assign w_over        = (r_accum > MaxDimVal);
    assign w_product     = 26'(w_rowlen) * 26'(r_height);
    assign w_out_free    = !r_out_valid || i_out_ready;
    assign w_is_pixel    = (i_cmd.kind == KIND_PIXEL);

    always_comb begin
        n_flip_rows   = r_flip_rows;
        n_flip_active = r_flip_active;
        n_grey        = r_grey;
        n_accum       = r_accum;
        n_digit_seen  = r_digit_seen;
        n_comment     = r_comment;
        n_width       = r_width;
        n_height      = r_height;
        n_maxval      = r_maxval;
        n_addr        = r_addr;
        n_row_cnt     = r_row_cnt;
        n_remaining   = r_remaining;
        n_total       = r_total;

        if (i_cfg_we) begin
            n_flip_rows = i_cfg_wdata;
        end

        if (i_cmd.clear) begin
            n_flip_active = 1'b0;
            n_grey        = 1'b0;
            n_accum       = '0;
            n_digit_seen  = 1'b0;
            n_comment     = 1'b0;
            n_width       = '0;
            n_height      = '0;
            n_maxval      = '0;
            n_addr        = '0;
            n_row_cnt     = '0;
            n_remaining   = '0;
        end

        unique case (i_cmd.op)
            OP_NONE: begin
            end
            OP_GREY: begin
                n_grey = (w_byte == CHAR_5);
            end
            OP_HDR_W, OP_HDR_H, OP_HDR_M: begin
                if (r_comment) begin
                    if (w_is_eol) begin
                        n_comment = 1'b0;
                    end
                end else if (w_is_digit) begin
                    n_accum      = (w_acc_wide > 20'hFFFF) ? 16'hFFFF : w_acc_wide[15:0];
                    n_digit_seen = 1'b1;
                end else if (!r_digit_seen) begin
                    if (w_is_hash) begin
                        n_comment = 1'b1;
                    end
                end else begin
                    n_accum      = '0;
                    n_digit_seen = 1'b0;
                    if (i_cmd.op == OP_HDR_M) begin
                        n_maxval = r_accum;
                    end else begin
                        // drop the comment when the number is rejected
                        n_comment = w_is_hash && !w_over;
                        if (!w_over) begin
                            if (i_cmd.op == OP_HDR_W) begin
                                n_width = r_accum[11:0];
                            end else begin
                                n_height = r_accum[11:0];
                            end
                        end
                    end
                end
            end
            OP_PIX: begin
                n_remaining = r_remaining - 24'd1;
                if (w_row_end) begin
                    n_row_cnt = '0;
                    n_addr    = r_flip_active ?
                                r_addr + 24'd1 - {9'b0, w_rowlen, 1'b0} : r_addr + 24'd1;
                end else begin
                    n_row_cnt = w_row_cnt_inc;
                    n_addr    = r_addr + 24'd1;
                end
            end
            OP_MUL: begin
                n_total       = w_product[23:0];
                n_flip_active = r_flip_rows;
            end
            OP_FIN: begin
                n_remaining = r_total;
                n_row_cnt   = '0;
                n_addr      = r_flip_active ? r_total - 24'(w_rowlen) : 24'd0;
            end
        endcase
    end

    // Output register: header fields after this update; address before it
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (i_cmd.emit) begin
            n_out_valid             = 1'b1;
            n_out_item.kind         = i_cmd.kind;
            n_out_item.address      = w_is_pixel ? r_addr : 24'd0;
            n_out_item.pixel_byte   = w_is_pixel ? w_byte : 8'd0;
            n_out_item.last         = w_is_pixel && (r_remaining == 24'd1);
            n_out_item.image_width  = n_width;
            n_out_item.image_height = n_height;
            n_out_item.max_value    = n_maxval;
            n_out_item.grey         = n_grey;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip_rows   <= 1'b0;
            r_flip_active <= 1'b0;
            r_grey        <= 1'b0;
            r_accum       <= '0;
            r_digit_seen  <= 1'b0;
            r_comment     <= 1'b0;
            r_width       <= '0;
            r_height      <= '0;
            r_maxval      <= '0;
            r_addr        <= '0;
            r_row_cnt     <= '0;
            r_remaining   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_flip_rows   <= n_flip_rows;
            r_flip_active <= n_flip_active;
            r_grey        <= n_grey;
            r_accum       <= n_accum;
            r_digit_seen  <= n_digit_seen;
            r_comment     <= n_comment;
            r_width       <= n_width;
            r_height      <= n_height;
            r_maxval      <= n_maxval;
            r_addr        <= n_addr;
            r_row_cnt     <= n_row_cnt;
            r_remaining   <= n_remaining;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total    <= n_total;
        r_out_item <= n_out_item;
    end

    assign o_sts.file_start     = i_in_item.file_start;
    assign o_sts.is_p           = (w_byte == CHAR_P);
    assign o_sts.is_magic_digit = (w_byte == CHAR_5) || (w_byte == CHAR_6);
    assign o_sts.sep            = w_sep;
    assign o_sts.over           = w_over;
    assign o_sts.last           = (r_remaining == 24'd1);
    assign o_sts.total_zero     = (r_total == 24'd0);
    assign o_sts.out_free       = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_pix_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_PIX |-> r_remaining != 24'd0)
        else $error("pixel step with no bytes remaining");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

endmodule

/* src/pbil_ctrl.sv */
module pbil_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pbil_pkg::t_dp_sts i_sts,
    output pbil_pkg::t_dp_cmd o_cmd
);
    import pbil_pkg::*;

    t_phase r_phase, n_phase;
    t_phase w_eff_phase;
    logic   w_accepting;
    logic   w_accept;

    assign w_accepting = (r_phase != PH_SIZE_MUL) && (r_phase != PH_SIZE_FIN);
    assign w_accept    = i_in_valid && o_in_ready;
    // a file start restarts the parse at the first magic byte
    assign w_eff_phase = i_sts.file_start ? PH_MAGIC_P : r_phase;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_SIZE_MUL: begin
                n_phase = PH_SIZE_FIN;
            end
            PH_SIZE_FIN: begin
                if (i_sts.out_free) begin
                    n_phase = i_sts.total_zero ? PH_IDLE : PH_PIXELS;
                end
            end
            PH_MAGIC_P, PH_MAGIC_D, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS,
            PH_IDLE: begin
                if (w_accept) begin
                    unique case (w_eff_phase)
                        PH_MAGIC_P: begin
                            n_phase = i_sts.is_p ? PH_MAGIC_D : PH_IDLE;
                        end
                        PH_MAGIC_D: begin
                            n_phase = i_sts.is_magic_digit ? PH_WIDTH : PH_IDLE;
                        end
                        PH_WIDTH: begin
                            if (i_sts.sep) begin
                                n_phase = i_sts.over ? PH_IDLE : PH_HEIGHT;
                            end
                        end
                        PH_HEIGHT: begin
                            if (i_sts.sep) begin
                                n_phase = i_sts.over ? PH_IDLE : PH_MAXVAL;
                            end
                        end
                        PH_MAXVAL: begin
                            if (i_sts.sep) begin
                                n_phase = PH_SIZE_MUL;
                            end
                        end
                        PH_PIXELS: begin
                            if (i_sts.last) begin
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_IDLE, PH_SIZE_MUL, PH_SIZE_FIN: begin
                            n_phase = w_eff_phase;
                        end
                    endcase
                end
            end
        endcase
    end

    always_comb begin
        o_in_ready = w_accepting && i_sts.out_free;
        o_cmd      = '{clear: 1'b0, op: OP_NONE, emit: 1'b0, kind: KIND_PIXEL};
        if (r_phase == PH_SIZE_MUL) begin
            o_cmd.op = OP_MUL;
        end else if (r_phase == PH_SIZE_FIN) begin
            if (i_sts.out_free) begin
                o_cmd.op   = OP_FIN;
                o_cmd.emit = 1'b1;
                o_cmd.kind = KIND_HEADER;
            end
        end else if (w_accept) begin
            o_cmd.clear = i_sts.file_start;
            unique case (w_eff_phase)
                PH_MAGIC_P: begin
                    if (!i_sts.is_p) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = KIND_BAD_MAGIC;
                    end
                end
                PH_MAGIC_D: begin
                    if (i_sts.is_magic_digit) begin
                        o_cmd.op = OP_GREY;
                    end else begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = KIND_BAD_MAGIC;
                    end
                end
                PH_WIDTH, PH_HEIGHT: begin
                    o_cmd.op = (w_eff_phase == PH_WIDTH) ? OP_HDR_W : OP_HDR_H;
                    if (i_sts.sep && i_sts.over) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = KIND_OVERSIZE;
                    end
                end
                PH_MAXVAL: begin
                    o_cmd.op = OP_HDR_M;
                end
                PH_PIXELS: begin
                    o_cmd.op   = OP_PIX;
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_PIXEL;
                end
                PH_IDLE, PH_SIZE_MUL, PH_SIZE_FIN: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC_P;
        end else begin
            r_phase <= n_phase;
        end
    end

    a_mul_then_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SIZE_MUL |=> r_phase == PH_SIZE_FIN)
        else $error("size multiply not followed by header finish");

    a_no_accept_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SIZE_MUL || r_phase == PH_SIZE_FIN) |-> !o_in_ready)
        else $error("input taken during size computation");

    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_sts.file_start && r_phase == PH_PIXELS && i_sts.last)
        |=> r_phase == PH_IDLE)
        else $error("parse not idle after final pixel byte");

endmodule
